FILE: rtl/rcae_pkg.sv
// ----------------------------------------------------------------------------
// rcae_pkg
// Shared types, widths and constants of the row cosine angle engine.
// ----------------------------------------------------------------------------
package rcae_pkg;

  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned ROW_W        = 6;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned ADDR_W       = ROW_W + COL_W;
  localparam int unsigned DEPTH        = 1 << ADDR_W;
  localparam int unsigned MAX_COLUMNS  = 1 << COL_W;
  localparam int unsigned NCOL_W       = COL_W + 1;
  localparam int unsigned PROD_W       = 2 * COUNT_W;
  localparam int unsigned ACC_W        = PROD_W + COL_W + 1;
  localparam int unsigned NUMX_W       = ACC_W + 60;
  localparam int unsigned ANGLE_W      = 14;
  localparam int unsigned ONE_Q16      = 65536;
  localparam int unsigned HALF_PI_Q16  = 102944;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 20;
  localparam int unsigned CORDIC_STEPS = 16;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_NORM,
    ST_SQA,
    ST_SQB,
    ST_MUL,
    ST_DIV,
    ST_CSQ,
    ST_SQC,
    ST_CORD,
    ST_FIN
  } state_e;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // atan(2^-i) in Q16
  function automatic logic [16:0] atan_q16(input logic [3:0] i);
    logic [16:0] r;
    unique case (i)
      4'd0:    r = 17'd51472;
      4'd1:    r = 17'd30385;
      4'd2:    r = 17'd16055;
      4'd3:    r = 17'd8150;
      4'd4:    r = 17'd4091;
      4'd5:    r = 17'd2047;
      4'd6:    r = 17'd1024;
      4'd7:    r = 17'd512;
      4'd8:    r = 17'd256;
      4'd9:    r = 17'd128;
      4'd10:   r = 17'd64;
      4'd11:   r = 17'd32;
      4'd12:   r = 17'd16;
      4'd13:   r = 17'd8;
      4'd14:   r = 17'd4;
      default: r = 17'd2;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/rcae_ram.sv
// ----------------------------------------------------------------------------
// rcae_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcae_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/row_cosine_angle_engine_unit.sv
// ----------------------------------------------------------------------------
// row_cosine_angle_engine_unit
// Count matrix of 64 rows by 256 columns with an angular-distance query.
// A load word (tuser = 0) writes one 16-bit count. A query word (tuser = 1)
// walks the first columns_in_use columns of two rows, one column per cycle
// from two mirrored store copies, then normalizes both squared norms, takes
// two square roots, divides (or sets the cosine to one when the aligned cross
// product overflows), takes one more root and runs a 16-step CORDIC. The
// column walk and the 32-step shared square-root unit dominate the query
// time. One result word leaves per query: angle in Q1.13 in tdata[13:0],
// zero-norm flag in tuser[0] (angle forced to 0). The output register holds
// a finished word while the next input word is taken. After reset a clearing
// pass zeroes all 16384 store words; no input word is taken until it ends.
// ----------------------------------------------------------------------------
module row_cosine_angle_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: columns_in_use
  input  logic                         cfg_we_i,
  input  logic [rcae_pkg::NCOL_W-1:0]  cfg_wdata_i,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // row_a [5:0], row_b [11:6], column_index [19:12], count_value [35:20]
  input  logic [39:0]                  s_axis_tdata_i,
  // action [0]
  input  logic [0:0]                   s_axis_tuser_i,
  // result stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // angle_q13 [13:0]
  output logic [15:0]                  m_axis_tdata_o,
  // zero_norm [0]
  output logic [0:0]                   m_axis_tuser_o
);

  import rcae_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [ADDR_W-1:0]  clr_cnt_q;
  logic [NCOL_W-1:0]  cols_q;
  logic [NCOL_W-1:0]  ncols;
  logic [NCOL_W-1:0]  col_q;
  logic               rd_vld_q, prd_vld_q;
  logic [4:0]         cnt_q;

  logic               s_acc;
  action_e            in_action;
  logic [ROW_W-1:0]   in_row_a, in_row_b;
  logic [COL_W-1:0]   in_col;
  logic [COUNT_W-1:0] in_count;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic [COUNT_W-1:0] rdata_a, rdata_b;

  logic [ROW_W-1:0]   row_a_q, row_b_q;
  logic [PROD_W-1:0]  a_sq_q, b_sq_q, ab_q;
  logic [ACC_W-1:0]   na_q, nb_q, d_q;
  logic [63:0]        na_s_q, nb_s_q;
  logic [5:0]         ka_q, kb_q;
  logic               zero_q;

  logic [63:0]        sq_v_q, sq_res_q, sq_bit_q;
  logic [63:0]        sq_trial, sq_v_nx, sq_res_nx;
  logic               sq_ge;

  logic [31:0]        sa_q, sb_q;
  logic [63:0]        den_q, rem_q, rem_nx;
  logic [19:0]        dbits_q, quo_q, quo_nx;
  logic [64:0]        dtrial;
  logic               dge;
  logic [16:0]        c_q, c_nx;
  logic [33:0]        cc_w;

  logic [6:0]         ksum;
  logic [5:0]         hsh;
  logic [NUMX_W-1:0]  num_w;
  logic               ovf_w;

  logic signed [19:0] x_q, y_q, xs, ys;
  logic signed [18:0] z_q, at_s;
  logic [16:0]        zc;
  logic [17:0]        zr;
  logic [ANGLE_W-1:0] angle_w;

  logic               issue, walk_done, norm_done;
  logic               sq_last, div_last, cord_last;
  logic               out_free;

  logic               m_valid_q;
  logic [ANGLE_W-1:0] m_angle_q;
  logic               m_zero_q;

  // shift toward zero on a signed value
  function automatic logic signed [19:0] shr_tz(input logic signed [19:0] v,
                                                input logic [3:0] s);
    logic [19:0] mag;
    mag = v[19] ? 20'(-v) : 20'(v);
    mag = mag >> s;
    return v[19] ? -$signed(mag) : $signed(mag);
  endfunction

  // --------------------------------------------------------------------------
  // Input unpack and handshake
  // --------------------------------------------------------------------------
  assign in_action = action_e'(s_axis_tuser_i[0]);
  assign in_row_a  = s_axis_tdata_i[5:0];
  assign in_row_b  = s_axis_tdata_i[11:6];
  assign in_col    = s_axis_tdata_i[19:12];
  assign in_count  = s_axis_tdata_i[35:20];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;

  // saturate the configured width to the store width
  assign ncols = (cols_q > NCOL_W'(MAX_COLUMNS)) ? NCOL_W'(MAX_COLUMNS) : cols_q;

  // --------------------------------------------------------------------------
  // Count store: two mirrored copies, one per row of the pair
  // --------------------------------------------------------------------------
  assign ram_we    = (state_q == ST_CLEAR) | (s_acc & (in_action == ACT_LOAD));
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : {in_row_a, in_col};
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : in_count;

  rcae_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({row_a_q, col_q[COL_W-1:0]}),
    .rdata_o (rdata_a)
  );

  rcae_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i ({row_b_q, col_q[COL_W-1:0]}),
    .rdata_o (rdata_b)
  );

  // --------------------------------------------------------------------------
  // Datapath combinational helpers
  // --------------------------------------------------------------------------
  assign issue     = (state_q == ST_WALK) && (col_q < ncols);
  assign walk_done = (state_q == ST_WALK) && !issue && !rd_vld_q && !prd_vld_q;
  assign norm_done = (|na_s_q[63:60]) && (|nb_s_q[63:60]);
  assign sq_last   = (cnt_q == 5'(SQRT_STEPS - 1));
  assign div_last  = (cnt_q == 5'(DIV_STEPS - 1));
  assign cord_last = (cnt_q == 5'(CORDIC_STEPS - 1));
  assign out_free  = !m_valid_q | m_axis_tready_i;

  // one step of the digit-by-digit square root
  assign sq_trial  = sq_res_q + sq_bit_q;
  assign sq_ge     = (sq_v_q >= sq_trial);
  assign sq_v_nx   = sq_ge ? (sq_v_q - sq_trial) : sq_v_q;
  assign sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  // align the cross product by half of the two normalizing shifts
  assign ksum  = 7'(ka_q) + 7'(kb_q);
  assign hsh   = ksum[6:1];
  assign num_w = NUMX_W'(d_q) << hsh;
  assign ovf_w = |num_w[NUMX_W-1:64];

  // one step of the restoring divider
  assign dtrial = {rem_q, dbits_q[19]};
  assign dge    = (dtrial >= {1'b0, den_q});
  always_comb begin
    logic [64:0] diff;
    diff   = dtrial - {1'b0, den_q};
    rem_nx = dge ? diff[63:0] : dtrial[63:0];
  end
  assign quo_nx = {quo_q[18:0], dge};
  assign c_nx   = (quo_nx > 20'(ONE_Q16)) ? 17'(ONE_Q16) : quo_nx[16:0];

  assign cc_w = 34'(c_q) * 34'(c_q);

  // CORDIC step operands
  assign xs   = shr_tz(x_q, cnt_q[3:0]);
  assign ys   = shr_tz(y_q, cnt_q[3:0]);
  assign at_s = $signed({2'b00, atan_q16(cnt_q[3:0])});

  // clamp the angle to [0, pi/2] and round to Q13
  assign zc      = z_q[18] ? '0 :
                   (z_q > 19'sd102944) ? 17'(HALF_PI_Q16) : z_q[16:0];
  assign zr      = 18'(zc) + 18'd4;
  assign angle_w = zr[16:3];

  // --------------------------------------------------------------------------
  // Control state machine
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (&clr_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_acc && (in_action == ACT_QUERY)) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ((na_q == '0) || (nb_q == '0)) ? ST_FIN : ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_done) state_d = ST_SQA;
      end
      ST_SQA: begin
        if (sq_last) state_d = ST_SQB;
      end
      ST_SQB: begin
        if (sq_last) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ovf_w ? ST_CSQ : ST_DIV;
      end
      ST_DIV: begin
        if (div_last) state_d = ST_CSQ;
      end
      ST_CSQ: begin
        state_d = ST_SQC;
      end
      ST_SQC: begin
        if (sq_last) state_d = ST_CORD;
      end
      ST_CORD: begin
        if (cord_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      cols_q    <= NCOL_W'(MAX_COLUMNS);
      col_q     <= '0;
      rd_vld_q  <= 1'b0;
      prd_vld_q <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we_i) cols_q <= cfg_wdata_i;

      // advance the column walk, track the read and product stages
      if (s_acc) col_q <= '0;
      else if (issue) col_q <= col_q + 1'b1;
      rd_vld_q  <= issue;
      prd_vld_q <= rd_vld_q;

      // shared step counter for root, divider and CORDIC
      if ((state_q == ST_SQA) || (state_q == ST_SQB) || (state_q == ST_SQC) ||
          (state_q == ST_DIV) || (state_q == ST_CORD)) begin
        if ((state_q == ST_DIV && div_last) || (state_q == ST_CORD && cord_last) ||
            sq_last) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else begin
        cnt_q <= '0;
      end

      // hold the result word until taken
      if (state_q == ST_FIN && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (s_acc && (in_action == ACT_QUERY)) begin
      row_a_q <= in_row_a;
      row_b_q <= in_row_b;
      na_q    <= '0;
      nb_q    <= '0;
      d_q     <= '0;
    end

    // column walk: square and cross products, then accumulate
    if (rd_vld_q) begin
      a_sq_q <= PROD_W'(rdata_a) * PROD_W'(rdata_a);
      b_sq_q <= PROD_W'(rdata_b) * PROD_W'(rdata_b);
      ab_q   <= PROD_W'(rdata_a) * PROD_W'(rdata_b);
    end
    if (prd_vld_q) begin
      na_q <= na_q + ACC_W'(a_sq_q);
      nb_q <= nb_q + ACC_W'(b_sq_q);
      d_q  <= d_q + ACC_W'(ab_q);
    end

    unique case (state_q)
      ST_WALK: begin
        if (walk_done) begin
          zero_q <= (na_q == '0) || (nb_q == '0);
          na_s_q <= 64'(na_q);
          nb_s_q <= 64'(nb_q);
          ka_q   <= '0;
          kb_q   <= '0;
        end
      end
      ST_NORM: begin
        // shift each norm up two bits until it reaches 2^60
        if (!(|na_s_q[63:60])) begin
          na_s_q <= na_s_q << 2;
          ka_q   <= ka_q + 6'd2;
        end
        if (!(|nb_s_q[63:60])) begin
          nb_s_q <= nb_s_q << 2;
          kb_q   <= kb_q + 6'd2;
        end
        if (norm_done) begin
          sq_v_q   <= na_s_q;
          sq_res_q <= '0;
          sq_bit_q <= 64'd1 << 62;
        end
      end
      ST_SQA, ST_SQB, ST_SQC: begin
        if (sq_last && state_q == ST_SQA) begin
          sa_q     <= sq_res_nx[31:0];
          sq_v_q   <= nb_s_q;
          sq_res_q <= '0;
          sq_bit_q <= 64'd1 << 62;
        end else begin
          sq_v_q   <= sq_v_nx;
          sq_res_q <= sq_res_nx;
          sq_bit_q <= sq_bit_q >> 2;
        end
        if (sq_last && state_q == ST_SQB) sb_q <= sq_res_nx[31:0];
        if (sq_last && state_q == ST_SQC) begin
          x_q <= 20'(c_q);
          y_q <= 20'(sq_res_nx[16:0]);
          z_q <= '0;
        end
      end
      ST_MUL: begin
        den_q   <= 64'(sa_q) * 64'(sb_q);
        rem_q   <= 64'(num_w[63:4]);
        dbits_q <= {num_w[3:0], 16'd0};
        quo_q   <= '0;
        if (ovf_w) c_q <= 17'(ONE_Q16);
      end
      ST_DIV: begin
        rem_q   <= rem_nx;
        dbits_q <= dbits_q << 1;
        quo_q   <= quo_nx;
        if (div_last) c_q <= c_nx;
      end
      ST_CSQ: begin
        sq_v_q   <= 64'(34'h1_0000_0000 - cc_w);
        sq_res_q <= '0;
        sq_bit_q <= 64'd1 << 62;
      end
      ST_CORD: begin
        if (!y_q[19]) begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at_s;
        end else begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at_s;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_angle_q <= zero_q ? '0 : angle_w;
          m_zero_q  <= zero_q;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = 16'(m_angle_q);
  assign m_axis_tuser_o  = m_zero_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_query_starts_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && in_action == ACT_QUERY) |=> (state_q == ST_WALK))
    else $error("query word did not start the column walk");

  a_store_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
    else $error("store written during a query");

  a_zero_angle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_zero_q) |-> (m_angle_q == '0))
    else $error("zero-norm result carries a nonzero angle");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_angle_q <= ANGLE_W'(12868)))
    else $error("angle above pi/2");

  a_cosine_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CSQ) |-> (c_q <= 17'(ONE_Q16)))
    else $error("cosine above one");

endmodule
